@@ hdl/lvg3_pkg.sv @@
// Package for the 3D voxel line generator.
// Holds the axis and sequencer state types and the default cube size.
// No dependencies; every other file of the block imports it.
package lvg3_pkg;

  localparam int unsigned CoordBitsDefault = 3;
  localparam int unsigned LevelBits        = 8;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK
  } state_e;

  // Sequencer controls for the datapath of the top level.
  typedef struct packed {
    logic ready;
    logic load;
    logic emit;
  } ctrl_t;

endpackage

@@ hdl/lvg3_setup.sv @@
// Line setup: per-axis distance and direction, major axis and the two
// starting error terms. Depends on lvg3_pkg.
module lvg3_setup import lvg3_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault,
  localparam int unsigned ErrW      = COORD_BITS + 3
) (
  input  logic [2:0][COORD_BITS-1:0] start_i,
  input  logic [2:0][COORD_BITS-1:0] fin_i,
  output logic [2:0][COORD_BITS-1:0] abs_o,
  output logic [2:0]                 neg_o,
  output axis_e                      major_o,
  output logic signed [ErrW-1:0]     err1_o,
  output logic signed [ErrW-1:0]     err2_o
);

  logic [COORD_BITS-1:0] a_maj, a_one, a_two;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_o[i] = fin_i[i] < start_i[i];
      abs_o[i] = neg_o[i] ? start_i[i] - fin_i[i] : fin_i[i] - start_i[i];
    end
  end

  // Ties go to x first, then y.
  always_comb begin
    priority if (abs_o[0] >= abs_o[1] && abs_o[0] >= abs_o[2]) begin
      major_o = AXIS_X;
    end else if (abs_o[1] >= abs_o[0] && abs_o[1] >= abs_o[2]) begin
      major_o = AXIS_Y;
    end else begin
      major_o = AXIS_Z;
    end
  end

  always_comb begin
    unique case (major_o)
      AXIS_X: begin
        a_maj = abs_o[0]; a_one = abs_o[1]; a_two = abs_o[2];
      end
      AXIS_Y: begin
        a_maj = abs_o[1]; a_one = abs_o[0]; a_two = abs_o[2];
      end
      default: begin
        a_maj = abs_o[2]; a_one = abs_o[1]; a_two = abs_o[0];
      end
    endcase
  end

  assign err1_o = $signed({2'b00, a_one, 1'b0}) - $signed({3'b000, a_maj});
  assign err2_o = $signed({2'b00, a_two, 1'b0}) - $signed({3'b000, a_maj});

endmodule

@@ hdl/lvg3_step_unit.sv @@
// Shared step unit: advances the walker by one voxel along the major axis
// and updates both error terms. Reused for every step of a line. Uses lvg3_pkg.
module lvg3_step_unit import lvg3_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault,
  localparam int unsigned ErrW      = COORD_BITS + 3
) (
  input  logic [2:0][COORD_BITS-1:0] cur_i,
  input  logic [2:0][COORD_BITS-1:0] abs_i,
  input  logic [2:0]                 neg_i,
  input  axis_e                      major_i,
  input  logic signed [ErrW-1:0]     err1_i,
  input  logic signed [ErrW-1:0]     err2_i,
  output logic [2:0][COORD_BITS-1:0] cur_o,
  output logic signed [ErrW-1:0]     err1_o,
  output logic signed [ErrW-1:0]     err2_o
);

  axis_e                 sec_one, sec_two;
  logic [COORD_BITS-1:0] a_maj, a_one, a_two;
  logic                  move_one, move_two;
  logic [2:0]            step;

  assign sec_one = (major_i == AXIS_Y) ? AXIS_X : AXIS_Y;
  assign sec_two = (major_i == AXIS_Z) ? AXIS_X : AXIS_Z;

  always_comb begin
    unique case (major_i)
      AXIS_X: begin
        a_maj = abs_i[0]; a_one = abs_i[1]; a_two = abs_i[2];
      end
      AXIS_Y: begin
        a_maj = abs_i[1]; a_one = abs_i[0]; a_two = abs_i[2];
      end
      default: begin
        a_maj = abs_i[2]; a_one = abs_i[1]; a_two = abs_i[0];
      end
    endcase
  end

  // A secondary axis moves when its error term is strictly positive.
  assign move_one = !err1_i[ErrW-1] && (err1_i != '0);
  assign move_two = !err2_i[ErrW-1] && (err2_i != '0);

  assign err1_o = err1_i + $signed({2'b00, a_one, 1'b0})
                - (move_one ? $signed({2'b00, a_maj, 1'b0}) : $signed(ErrW'(0)));
  assign err2_o = err2_i + $signed({2'b00, a_two, 1'b0})
                - (move_two ? $signed({2'b00, a_maj, 1'b0}) : $signed(ErrW'(0)));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      step[i] = (axis_e'(i) == major_i)
             || (axis_e'(i) == sec_one && move_one)
             || (axis_e'(i) == sec_two && move_two);
      if (!step[i]) begin
        cur_o[i] = cur_i[i];
      end else if (neg_i[i]) begin
        cur_o[i] = cur_i[i] - COORD_BITS'(1);
      end else begin
        cur_o[i] = cur_i[i] + COORD_BITS'(1);
      end
    end
  end

endmodule

@@ hdl/line_voxel_generator_3d.sv @@
// Top level of the 3D voxel line generator: input register, sequencer,
// walker registers and output register. Uses lvg3_pkg, lvg3_setup and
// lvg3_step_unit.
//
// Usage: the slave stream takes one item per line: start and end voxel of a
// cube with 2^COORD_BITS voxels on each edge, plus a brightness level. The
// master stream returns every voxel of the line from start to end, one item
// each, with the level copied and tlast set on the end point. A line of
// n = max(|dx|,|dy|,|dz|) major steps gives n+1 items.
// Operation: after an item is accepted into the input register, the setup
// state computes the deltas, the major axis and the error terms and loads
// them into the walker registers; then the shared step unit produces one
// voxel per cycle while the receiver does not stall, via the output register.
// s_axis_tready returns once the end point has been emitted.
// The block takes one line at a time and is not ready while it walks.
// A finished voxel sits in the output register; when the receiver stalls,
// the walker holds until that register is taken, so nothing is lost.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and empties
// the output register; no state carries over from one line to the next.
module line_voxel_generator_3d import lvg3_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault,
  localparam int unsigned ErrW      = COORD_BITS + 3,
  localparam int unsigned InW       = 6 * COORD_BITS + LevelBits,
  localparam int unsigned InTdataW  = ((InW + 7) / 8) * 8,
  localparam int unsigned OutW      = 3 * COORD_BITS + LevelBits,
  localparam int unsigned OutTdataW = ((OutW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, level
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // voxel_x, voxel_y, voxel_z, voxel_level
  output logic [OutTdataW-1:0] m_axis_tdata,
  output logic                 m_axis_tlast
);

  state_e state_q, state_d;
  ctrl_t  ctrl;

  logic [InW-1:0]                in_q;
  logic [2:0][COORD_BITS-1:0]    start_w, fin_w;
  logic [LevelBits-1:0]          level_w;

  logic [2:0][COORD_BITS-1:0]    abs_d, abs_q;
  logic [2:0]                    neg_d, neg_q;
  axis_e                         major_d, major_q;
  logic signed [ErrW-1:0]        err1_init, err2_init, err1_next, err2_next;
  logic signed [ErrW-1:0]        err1_q, err2_q;
  logic [2:0][COORD_BITS-1:0]    cur_q, cur_next;
  logic [COORD_BITS-1:0]         steps_q;

  logic                          out_valid_q;
  logic [2:0][COORD_BITS-1:0]    out_cur_q;
  logic [LevelBits-1:0]          out_level_q;
  logic                          out_last_q;
  logic                          out_free;
  logic                          last_step;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign start_w[i] = in_q[i*COORD_BITS +: COORD_BITS];
    assign fin_w[i]   = in_q[(i+3)*COORD_BITS +: COORD_BITS];
  end
  assign level_w = in_q[6*COORD_BITS +: LevelBits];

  lvg3_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .start_i (start_w),
    .fin_i   (fin_w),
    .abs_o   (abs_d),
    .neg_o   (neg_d),
    .major_o (major_d),
    .err1_o  (err1_init),
    .err2_o  (err2_init)
  );

  lvg3_step_unit #(.COORD_BITS(COORD_BITS)) u_step (
    .cur_i   (cur_q),
    .abs_i   (abs_q),
    .neg_i   (neg_q),
    .major_i (major_q),
    .err1_i  (err1_q),
    .err2_i  (err2_q),
    .cur_o   (cur_next),
    .err1_o  (err1_next),
    .err2_o  (err2_next)
  );

  assign out_free  = !out_valid_q || m_axis_tready;
  assign last_step = (steps_q == '0);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_WALK;
      ST_WALK:  if (out_free && last_step) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE:  ctrl.ready = 1'b1;
      ST_SETUP: ctrl.load  = 1'b1;
      ST_WALK:  ctrl.emit  = out_free;
      default:  ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ready && s_axis_tvalid) begin
      in_q <= s_axis_tdata[InW-1:0];
    end
    if (ctrl.load) begin
      abs_q   <= abs_d;
      neg_q   <= neg_d;
      major_q <= major_d;
      err1_q  <= err1_init;
      err2_q  <= err2_init;
      cur_q   <= start_w;
      unique case (major_d)
        AXIS_X:  steps_q <= abs_d[0];
        AXIS_Y:  steps_q <= abs_d[1];
        default: steps_q <= abs_d[2];
      endcase
    end else if (ctrl.emit && !last_step) begin
      cur_q   <= cur_next;
      err1_q  <= err1_next;
      err2_q  <= err2_next;
      steps_q <= steps_q - COORD_BITS'(1);
    end
    if (ctrl.emit) begin
      out_cur_q   <= cur_q;
      out_level_q <= level_w;
      out_last_q  <= last_step;
    end
  end

  assign s_axis_tready = ctrl.ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OutTdataW'({out_level_q, out_cur_q[2], out_cur_q[1], out_cur_q[0]});

  // An accepted item always goes through the setup cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == ST_SETUP)
    else $error("accepted item did not enter setup");

  // Emitting the final voxel ends the walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK && out_free && last_step |=> state_q == ST_IDLE && m_axis_tlast)
    else $error("walk did not end on the final voxel");

  // The voxel marked last is the end point of the line just walked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && m_axis_tvalid && m_axis_tlast |->
      out_cur_q[0] == fin_w[0] && out_cur_q[1] == fin_w[1] && out_cur_q[2] == fin_w[2])
    else $error("last voxel differs from the end point");

  // The block never takes a new item while the walker is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !s_axis_tready)
    else $error("ready raised during a walk");

endmodule

@@ tb/sv/line_voxel_generator_3d_checker.sv @@
`timescale 1ns / 100ps
// Checker for the 3D voxel line generator: watches both streams, traces each
// accepted line into the voxels it must produce and compares every output item.
// Depends on lvg3_pkg for the cube size, the level width and the axis type.
module line_voxel_generator_3d_checker import lvg3_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDefault,
  localparam int unsigned InTdataW  = ((6 * CoordBits + LevelBits + 7) / 8) * 8,
  localparam int unsigned OutTdataW = ((3 * CoordBits + LevelBits + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  // start_x, start_y, start_z, end_x, end_y, end_z, level
  input  logic [InTdataW-1:0]  s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  // voxel_x, voxel_y, voxel_z, voxel_level
  input  logic [OutTdataW-1:0] m_tdata_i,
  input  logic                 m_tlast_i,
  output int                   error_count_o,
  output int                   pending_o
);

  localparam int CoordMask = (1 << CoordBits) - 1;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] z;
    logic [LevelBits-1:0] level;
    logic                 last;
  } voxel_t;

  voxel_t expected_voxels[$];

  function automatic void push_voxel(input int pos[3], input logic [LevelBits-1:0] lvl,
                                     input logic fin);
    voxel_t v;
    v.x     = pos[0][CoordBits-1:0];
    v.y     = pos[1][CoordBits-1:0];
    v.z     = pos[2][CoordBits-1:0];
    v.level = lvl;
    v.last  = fin;
    expected_voxels.push_back(v);
  endfunction

  // Walks one line with integer Bresenham along the dominant axis and queues
  // every voxel from the start point to the end point.
  function automatic void trace_line(input logic [InTdataW-1:0] d);
    int pos[3];
    int target[3];
    int span[3];
    int sgn[3];
    int err_a;
    int err_b;
    int mj;
    int sec_a;
    int sec_b;
    axis_e major;
    logic [LevelBits-1:0] lvl;
    for (int i = 0; i < 3; i++) begin
      pos[i]    = int'(d[i*CoordBits +: CoordBits]);
      target[i] = int'(d[(i+3)*CoordBits +: CoordBits]);
      sgn[i]    = (target[i] < pos[i]) ? -1 : 1;
      span[i]   = (target[i] < pos[i]) ? pos[i] - target[i] : target[i] - pos[i];
    end
    lvl = d[6*CoordBits +: LevelBits];

    // Ties go to x first, then y.
    if (span[0] >= span[1] && span[0] >= span[2]) begin
      major = AXIS_X; sec_a = 1; sec_b = 2;
    end else if (span[1] >= span[0] && span[1] >= span[2]) begin
      major = AXIS_Y; sec_a = 0; sec_b = 2;
    end else begin
      major = AXIS_Z; sec_a = 1; sec_b = 0;
    end
    mj = int'(major);

    err_a = 2 * span[sec_a] - span[mj];
    err_b = 2 * span[sec_b] - span[mj];
    for (int k = 0; k < span[mj]; k++) begin
      push_voxel(pos, lvl, 1'b0);
      if (err_a > 0) begin
        pos[sec_a] = (pos[sec_a] + sgn[sec_a]) & CoordMask;
        err_a -= 2 * span[mj];
      end
      if (err_b > 0) begin
        pos[sec_b] = (pos[sec_b] + sgn[sec_b]) & CoordMask;
        err_b -= 2 * span[mj];
      end
      err_a += 2 * span[sec_a];
      err_b += 2 * span[sec_b];
      pos[mj] = (pos[mj] + sgn[mj]) & CoordMask;
    end
    push_voxel(pos, lvl, 1'b1);
  endfunction

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  always @(posedge clk_i) begin
    voxel_t seen;
    voxel_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) begin
        trace_line(s_tdata_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        seen.x     = m_tdata_i[0 +: CoordBits];
        seen.y     = m_tdata_i[CoordBits +: CoordBits];
        seen.z     = m_tdata_i[2*CoordBits +: CoordBits];
        seen.level = m_tdata_i[3*CoordBits +: LevelBits];
        seen.last  = m_tlast_i;
        if (expected_voxels.size() == 0) begin
          if (error_count_o < 10) begin
            $display("%0t: voxel with no line pending: x=%0d y=%0d z=%0d level=%0d last=%0b",
                     $realtime, seen.x, seen.y, seen.z, seen.level, seen.last);
          end
          error_count_o++;
        end else begin
          want = expected_voxels.pop_front();
          if (seen.x !== want.x || seen.y !== want.y || seen.z !== want.z ||
              seen.level !== want.level || seen.last !== want.last) begin
            if (error_count_o < 10) begin
              $display("%0t: voxel mismatch: expected x=%0d y=%0d z=%0d level=%0d last=%0b",
                       $realtime, want.x, want.y, want.z, want.level, want.last);
              $display("%0t:                 actual   x=%0d y=%0d z=%0d level=%0d last=%0b",
                       $realtime, seen.x, seen.y, seen.z, seen.level, seen.last);
            end
            error_count_o++;
          end
        end
      end
      pending_o = expected_voxels.size();
    end
  end

endmodule

@@ tb/sv/line_voxel_generator_3d_test.sv @@
`timescale 1ns / 100ps
// Top of the testbench for the 3D voxel line generator: clock, reset, line
// stimulus, output back-pressure, watchdog and verdict.
// Depends on lvg3_pkg, line_voxel_generator_3d and line_voxel_generator_3d_checker.
module line_voxel_generator_3d_test;
  import lvg3_pkg::*;

  localparam int unsigned CoordBits = CoordBitsDefault;
  localparam int unsigned InTdataW  = ((6 * CoordBits + LevelBits + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((3 * CoordBits + LevelBits + 7) / 8) * 8;
  localparam int RandomLines = 380;
  localparam int HoldCycles  = 100;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 16;

  // Last member sits in the lowest bits, so start_x lands at bit 0.
  typedef struct packed {
    logic [LevelBits-1:0] level;
    logic [CoordBits-1:0] end_z;
    logic [CoordBits-1:0] end_y;
    logic [CoordBits-1:0] end_x;
    logic [CoordBits-1:0] start_z;
    logic [CoordBits-1:0] start_y;
    logic [CoordBits-1:0] start_x;
  } line_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  int error_count;
  int pending;
  int idle_cycles = 0;
  bit calm_stretch = 1'b0;
  bit hold_rx_req = 1'b0;

  line_voxel_generator_3d #(.COORD_BITS(CoordBits)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  line_voxel_generator_3d_checker #(.CoordBits(CoordBits)) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tlast_i     (m_axis_tlast),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic line_t make_line(input int sx, input int sy, input int sz,
                                      input int ex, input int ey, input int ez,
                                      input int lvl);
    line_t ln;
    ln.start_x = sx[CoordBits-1:0];
    ln.start_y = sy[CoordBits-1:0];
    ln.start_z = sz[CoordBits-1:0];
    ln.end_x   = ex[CoordBits-1:0];
    ln.end_y   = ey[CoordBits-1:0];
    ln.end_z   = ez[CoordBits-1:0];
    ln.level   = lvl[LevelBits-1:0];
    return ln;
  endfunction

  // Mostly uniform lines, with a share of zero-length lines and of lines
  // whose spans tie so that the axis priority is exercised.
  function automatic line_t random_line();
    line_t ln;
    ln = line_t'($bits(line_t)'($urandom));
    case ($urandom_range(0, 9))
      0: begin
        ln.end_x = ln.start_x; ln.end_y = ln.start_y; ln.end_z = ln.start_z;
      end
      1: begin
        ln.start_y = ln.start_x; ln.end_y = ln.end_x;
      end
      2: begin
        ln.start_z = ln.start_y; ln.end_z = ln.end_y;
      end
      3: begin
        ln.start_z = ln.start_x; ln.end_z = ln.end_x;
      end
      default: ;
    endcase
    return ln;
  endfunction

  task automatic send_line(input line_t ln);
    if (!calm_stretch && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InTdataW'(ln);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering lines until every voxel already owed has come out.
  task automatic drain_voxels();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Receiver side: random back-pressure, a long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx_req = 1'b0;
      end
      m_axis_tready <= calm_stretch || ($urandom_range(0, 99) >= 17);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    line_t directed[$];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero-length lines, full diagonals, each major axis, each tie and
    // single steps, with the coordinate and level extremes.
    directed.push_back(make_line(0, 0, 0, 0, 0, 0, 8'h00));
    directed.push_back(make_line(7, 7, 7, 7, 7, 7, 8'hFF));
    directed.push_back(make_line(0, 0, 0, 7, 7, 7, 8'h55));
    directed.push_back(make_line(7, 7, 7, 0, 0, 0, 8'hAA));
    directed.push_back(make_line(0, 0, 0, 7, 3, 1, 8'h01));
    directed.push_back(make_line(7, 0, 7, 2, 7, 4, 8'h80));
    directed.push_back(make_line(3, 6, 0, 1, 5, 7, 8'h7F));
    directed.push_back(make_line(0, 7, 3, 5, 2, 3, 8'hC3));
    directed.push_back(make_line(4, 0, 0, 4, 6, 6, 8'h3C));
    directed.push_back(make_line(6, 1, 6, 2, 1, 2, 8'h0F));
    directed.push_back(make_line(2, 2, 2, 3, 2, 2, 8'hF0));
    directed.push_back(make_line(5, 5, 5, 5, 4, 5, 8'h12));
    directed.push_back(make_line(1, 2, 3, 1, 2, 0, 8'hED));
    directed.push_back(make_line(7, 0, 7, 0, 7, 0, 8'h99));
    directed.push_back(make_line(0, 7, 0, 7, 0, 7, 8'h66));
    directed.push_back(make_line(3, 4, 5, 3, 4, 5, 8'hFE));
    directed.push_back(make_line(0, 0, 7, 1, 6, 0, 8'h5A));
    foreach (directed[i]) send_line(directed[i]);
    drain_voxels();

    for (int n = 0; n < RandomLines; n++) begin
      if (n == 120) drain_voxels();
      // The receiver stalls while lines keep coming, so the block backs up.
      if (n == 200) hold_rx_req = 1'b1;
      calm_stretch = (n >= 250 && n < 320);
      send_line(random_line());
    end
    calm_stretch = 1'b0;

    drain_voxels();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
